[src/calda_pkg.sv]
// Package with the types, codes and calendar tables of the date-time advance block.
`default_nettype none

package calda_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_SUB,
    ST_FIX,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    STEP_MS,
    STEP_SEC,
    STEP_MIN,
    STEP_HOUR,
    STEP_MON,
    STEP_YEAR
  } step_e;

  localparam logic [2:0] FUNC_YEAR   = 3'd0;
  localparam logic [2:0] FUNC_MONTH  = 3'd1;
  localparam logic [2:0] FUNC_DAY    = 3'd2;
  localparam logic [2:0] FUNC_HOUR   = 3'd3;
  localparam logic [2:0] FUNC_MINUTE = 3'd4;
  localparam logic [2:0] FUNC_SECOND = 3'd5;
  localparam logic [2:0] FUNC_MILLI  = 3'd6;

  localparam int unsigned DivW = 10;

  localparam logic [DivW-1:0] MsPerSec   = 10'd1000;
  localparam logic [DivW-1:0] SecPerMin  = 10'd60;
  localparam logic [DivW-1:0] MinPerHour = 10'd60;
  localparam logic [DivW-1:0] HourPerDay = 10'd24;
  localparam logic [DivW-1:0] MonPerYear = 10'd12;
  localparam logic [DivW-1:0] LeapCycle  = 10'd400;

  localparam logic [3:0] MonthDec = 4'd12;
  localparam logic [8:0] CycleEnd = 9'd399;

  function automatic logic [DivW-1:0] step_divisor(input step_e step);
    logic [DivW-1:0] d;
    d = MsPerSec;
    unique case (step)
      STEP_MS:   d = MsPerSec;
      STEP_SEC:  d = SecPerMin;
      STEP_MIN:  d = MinPerHour;
      STEP_HOUR: d = HourPerDay;
      STEP_MON:  d = MonPerYear;
      STEP_YEAR: d = LeapCycle;
      default:   d = MsPerSec;
    endcase
    return d;
  endfunction

  // The year is held modulo 400, so the century rule needs only a few compares.
  function automatic logic is_leap(input logic [8:0] y400);
    return (y400 == 9'd0) ||
           ((y400[1:0] == 2'b00) && (y400 != 9'd100) && (y400 != 9'd200) &&
            (y400 != 9'd300));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    case (mo)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[src/calendar_datetime_advance_top.sv]
// Top level of the Gregorian date-time advance block with its shared multiplier and month walk.
//
// Usage: drive the date-time fields, func_i and delay_i, and raise start while busy is
// low; the item transfers at that clock edge and busy rises in the next cycle.
// The delay is added to the unit chosen by func_i, then the time fields are carried
// upwards and the day is reduced month by month until it fits its month.
// One multiplier serves six divisions by constants in turn: milliseconds by 1000,
// seconds and minutes by 60, hours by 24, months by 12 and the year by 400 (the year
// is then tracked modulo 400 for the leap-year rule). Each division runs through
// load, multiply by a scaled reciprocal, multiply back, and one compare and subtract
// that corrects the quotient. The month walk steps over one month at a time.
// The result stands on the output ports for one cycle with done_o high; busy stays high
// through that cycle and falls after it, so a new item can transfer only once the last
// result has been given.
// The receiver cannot hold a result off; it must take it in the done_o cycle.
// Reset returns the block to idle and drops any item in progress.
`default_nettype none

module calendar_datetime_advance_top #(
  parameter int unsigned DELAY_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [2:0]            func_i,
  input  wire logic [DELAY_BITS-1:0] delay_i,
  input  wire logic [13:0]           year_in_i,
  input  wire logic [3:0]            month_in_i,
  input  wire logic [4:0]            day_in_i,
  input  wire logic [4:0]            hour_in_i,
  input  wire logic [5:0]            minute_in_i,
  input  wire logic [5:0]            second_in_i,
  input  wire logic [9:0]            milli_in_i,
  output      logic                  done_o,
  output      logic [16:0]           year_out_o,
  output      logic [3:0]            month_out_o,
  output      logic [4:0]            day_out_o,
  output      logic [4:0]            hour_out_o,
  output      logic [5:0]            minute_out_o,
  output      logic [5:0]            second_out_o,
  output      logic [9:0]            milli_out_o
);
  import calda_pkg::*;

  localparam int unsigned VW = ((DELAY_BITS > 14) ? DELAY_BITS : 14) + 1;
  localparam int unsigned YW = VW + 1;
  localparam int unsigned PW = 2 * VW;

  localparam logic [VW-1:0] RecipMs   = VW'((64'd1 << VW) / 64'(MsPerSec));
  localparam logic [VW-1:0] RecipSec  = VW'((64'd1 << VW) / 64'(SecPerMin));
  localparam logic [VW-1:0] RecipMin  = VW'((64'd1 << VW) / 64'(MinPerHour));
  localparam logic [VW-1:0] RecipHour = VW'((64'd1 << VW) / 64'(HourPerDay));
  localparam logic [VW-1:0] RecipMon  = VW'((64'd1 << VW) / 64'(MonPerYear));
  localparam logic [VW-1:0] RecipYear = VW'((64'd1 << VW) / 64'(LeapCycle));

  state_e           state_q, state_d;
  step_e            step_q, step_d;

  logic [VW-1:0]    nq_q, nq_d;
  logic [VW-1:0]    quo_q, quo_d;
  logic [DivW:0]    rem_q, rem_d;
  logic [YW-1:0]    yr_q, yr_d;
  logic [VW-1:0]    mo_q, mo_d;
  logic [VW-1:0]    dy_q, dy_d;
  logic [VW-1:0]    hr_q, hr_d;
  logic [VW-1:0]    mi_q, mi_d;
  logic [VW-1:0]    se_q, se_d;
  logic [VW-1:0]    ms_q, ms_d;
  logic [8:0]       y400_q, y400_d;

  logic [DivW-1:0]  divisor;
  logic [VW-1:0]    recip;
  logic [VW-1:0]    mul_a;
  logic [VW-1:0]    mul_b;
  logic [PW-1:0]    prod;
  logic [VW-1:0]    resid;
  logic             ge;
  logic [DivW:0]    diff;
  logic [DivW-1:0]  rem_fix;
  logic [VW-1:0]    quo_fix;
  logic [VW-1:0]    dl;
  logic [4:0]       len;

  always_comb begin
    unique case (step_q)
      STEP_MS:   recip = RecipMs;
      STEP_SEC:  recip = RecipSec;
      STEP_MIN:  recip = RecipMin;
      STEP_HOUR: recip = RecipHour;
      STEP_MON:  recip = RecipMon;
      STEP_YEAR: recip = RecipYear;
      default:   recip = RecipMs;
    endcase
  end

  // The scaled reciprocal is rounded down, so the first quotient is exact or one short.
  assign divisor = step_divisor(step_q);
  assign mul_a   = (state_q == ST_MUL) ? nq_q : quo_q;
  assign mul_b   = (state_q == ST_MUL) ? recip : VW'(divisor);
  assign prod    = PW'(mul_a) * PW'(mul_b);
  assign resid   = nq_q - prod[VW-1:0];
  assign ge      = rem_q >= {1'b0, divisor};
  assign diff    = rem_q - {1'b0, divisor};
  assign rem_fix = ge ? diff[DivW-1:0] : rem_q[DivW-1:0];
  assign quo_fix = quo_q + VW'(ge);
  assign dl      = VW'(delay_i);
  assign len     = month_len(mo_q[3:0], is_leap(y400_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_MS;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q   <= nq_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    yr_q   <= yr_d;
    mo_q   <= mo_d;
    dy_q   <= dy_d;
    hr_q   <= hr_d;
    mi_q   <= mi_d;
    se_q   <= se_d;
    ms_q   <= ms_d;
    y400_q <= y400_d;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    nq_d    = nq_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    yr_d    = yr_q;
    mo_d    = mo_q;
    dy_d    = dy_q;
    hr_d    = hr_q;
    mi_d    = mi_q;
    se_d    = se_q;
    ms_d    = ms_q;
    y400_d  = y400_q;
    done_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          yr_d = YW'(year_in_i);
          mo_d = (month_in_i == 4'd0) ? VW'(1) : VW'(month_in_i);
          dy_d = (day_in_i == 5'd0) ? VW'(1) : VW'(day_in_i);
          hr_d = VW'(hour_in_i);
          mi_d = VW'(minute_in_i);
          se_d = VW'(second_in_i);
          ms_d = VW'(milli_in_i);
          case (func_i)
            FUNC_YEAR:   yr_d = YW'(year_in_i) + YW'(delay_i);
            FUNC_MONTH:  mo_d = ((month_in_i == 4'd0) ? VW'(1) : VW'(month_in_i)) + dl;
            FUNC_DAY:    dy_d = ((day_in_i == 5'd0) ? VW'(1) : VW'(day_in_i)) + dl;
            FUNC_HOUR:   hr_d = VW'(hour_in_i) + dl;
            FUNC_MINUTE: mi_d = VW'(minute_in_i) + dl;
            FUNC_SECOND: se_d = VW'(second_in_i) + dl;
            FUNC_MILLI:  ms_d = VW'(milli_in_i) + dl;
            default:     ;
          endcase
          step_d  = STEP_MS;
          state_d = ST_LOAD;
        end
      end

      ST_LOAD: begin
        unique case (step_q)
          STEP_MS:   nq_d = ms_q;
          STEP_SEC:  nq_d = se_q;
          STEP_MIN:  nq_d = mi_q;
          STEP_HOUR: nq_d = hr_q;
          STEP_MON:  nq_d = mo_q - VW'(1);
          STEP_YEAR: nq_d = yr_q[VW-1:0];
          default:   nq_d = ms_q;
        endcase
        state_d = ST_MUL;
      end

      ST_MUL: begin
        quo_d   = prod[PW-1:VW];
        state_d = ST_SUB;
      end

      ST_SUB: begin
        rem_d   = resid[DivW:0];
        state_d = ST_FIX;
      end

      ST_FIX: begin
        state_d = ST_LOAD;
        unique case (step_q)
          STEP_MS: begin
            ms_d   = VW'(rem_fix);
            se_d   = se_q + quo_fix;
            step_d = STEP_SEC;
          end
          STEP_SEC: begin
            se_d   = VW'(rem_fix);
            mi_d   = mi_q + quo_fix;
            step_d = STEP_MIN;
          end
          STEP_MIN: begin
            mi_d   = VW'(rem_fix);
            hr_d   = hr_q + quo_fix;
            step_d = STEP_HOUR;
          end
          STEP_HOUR: begin
            hr_d   = VW'(rem_fix);
            dy_d   = dy_q + quo_fix;
            step_d = STEP_MON;
          end
          STEP_MON: begin
            mo_d   = VW'(rem_fix) + VW'(1);
            yr_d   = yr_q + YW'(quo_fix);
            step_d = STEP_YEAR;
          end
          STEP_YEAR: begin
            y400_d  = rem_fix[8:0];
            step_d  = STEP_MS;
            state_d = ST_WALK;
          end
          default: begin
            step_d = STEP_MS;
          end
        endcase
      end

      ST_WALK: begin
        if (dy_q <= VW'(len)) begin
          state_d = ST_DONE;
        end else begin
          dy_d = dy_q - VW'(len);
          if (mo_q[3:0] == MonthDec) begin
            mo_d   = VW'(1);
            yr_d   = yr_q + YW'(1);
            y400_d = (y400_q == CycleEnd) ? 9'd0 : y400_q + 9'd1;
          end else begin
            mo_d = mo_q + VW'(1);
          end
        end
      end

      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy         = (state_q != ST_IDLE);
  assign year_out_o   = 17'(yr_q);
  assign month_out_o  = mo_q[3:0];
  assign day_out_o    = dy_q[4:0];
  assign hour_out_o   = hr_q[4:0];
  assign minute_out_o = mi_q[5:0];
  assign second_out_o = se_q[5:0];
  assign milli_out_o  = ms_q[9:0];

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("A transfer did not make the block busy.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == ST_IDLE))
    else $error("The block did not return to idle after a result.");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIX) |-> (rem_q < ({1'b0, divisor} << 1)))
    else $error("The divider remainder exceeded twice its divisor.");

  a_walk_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((mo_q >= VW'(1)) && (mo_q <= VW'(12)) && (y400_q <= CycleEnd)))
    else $error("The month walk left the calendar range.");
`endif

endmodule

`default_nettype wire
